// ===== rtl/xmt_pkg.sv =====
// Shared types and constants for the XML markup tokenizer.
package xmt_pkg;

    localparam int STACK_DEPTH_DEF = 16;
    localparam int NAME_BYTES_DEF  = 32;

    localparam logic [7:0] CH_LT    = 8'h3C;
    localparam logic [7:0] CH_GT    = 8'h3E;
    localparam logic [7:0] CH_SLASH = 8'h2F;
    localparam logic [7:0] CH_EQ    = 8'h3D;
    localparam logic [7:0] CH_QMARK = 8'h3F;
    localparam logic [7:0] CH_BANG  = 8'h21;
    localparam logic [7:0] CH_DASH  = 8'h2D;
    localparam logic [7:0] CH_LBR   = 8'h5B;
    localparam logic [7:0] CH_RBR   = 8'h5D;
    localparam logic [7:0] CH_QUOTE = 8'h22;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_C     = 8'h43;
    localparam logic [7:0] CH_D     = 8'h44;
    localparam logic [7:0] CH_A     = 8'h41;
    localparam logic [7:0] CH_T     = 8'h54;

    localparam logic [3:0] EV_NONE      = 4'd0;
    localparam logic [3:0] EV_START     = 4'd1;
    localparam logic [3:0] EV_END       = 4'd2;
    localparam logic [3:0] EV_EMPTY     = 4'd3;
    localparam logic [3:0] EV_ANAME_SP  = 4'd4;
    localparam logic [3:0] EV_NO_QUOTE  = 4'd5;
    localparam logic [3:0] EV_NO_GT     = 4'd6;
    localparam logic [3:0] EV_MISMATCH  = 4'd7;
    localparam logic [3:0] EV_JUNK      = 4'd8;
    localparam logic [3:0] EV_BAD_CMT   = 4'd9;
    localparam logic [3:0] EV_UNDERFLOW = 4'd10;
    localparam logic [3:0] EV_OVERFLOW  = 4'd11;
    localparam logic [3:0] EV_NAME_LONG = 4'd12;

    localparam logic [2:0] ROLE_MARKUP = 3'd0;
    localparam logic [2:0] ROLE_ELEM   = 3'd1;
    localparam logic [2:0] ROLE_ANAME  = 3'd2;
    localparam logic [2:0] ROLE_AVAL   = 3'd3;
    localparam logic [2:0] ROLE_TEXT   = 3'd4;
    localparam logic [2:0] ROLE_ENAME  = 3'd5;

    typedef enum logic [27:0] {
        ST_OUT    = 28'h0000001,
        ST_LT     = 28'h0000002,
        ST_NAME   = 28'h0000004,
        ST_ATTRS  = 28'h0000008,
        ST_ANAME  = 28'h0000010,
        ST_EQ     = 28'h0000020,
        ST_VAL    = 28'h0000040,
        ST_SLASH  = 28'h0000080,
        ST_ENAME  = 28'h0000100,
        ST_EEND   = 28'h0000200,
        ST_PI     = 28'h0000400,
        ST_PIQ    = 28'h0000800,
        ST_BANG   = 28'h0001000,
        ST_SKIP   = 28'h0002000,
        ST_CM0    = 28'h0004000,
        ST_CM1    = 28'h0008000,
        ST_CM2    = 28'h0010000,
        ST_CM3    = 28'h0020000,
        ST_CD0    = 28'h0040000,
        ST_CD1    = 28'h0080000,
        ST_CD2    = 28'h0100000,
        ST_CD3    = 28'h0200000,
        ST_CD4    = 28'h0400000,
        ST_CD5    = 28'h0800000,
        ST_CDBODY = 28'h1000000,
        ST_CDB1   = 28'h2000000,
        ST_CDB2   = 28'h4000000,
        ST_TEXT   = 28'h8000000
    } t_state;

    typedef struct packed {
        logic [7:0] data;
        logic       lt;
        logic       gt;
        logic       slash;
        logic       eq;
        logic       qmark;
        logic       bang;
        logic       dash;
        logic       lbr;
        logic       rbr;
        logic       quote;
        logic       lf;
        logic       blank;
    } t_cls;

endpackage

// ===== rtl/xmt_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module xmt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 512
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/xmt_front.sv =====
// Front end: accepts bytes, classifies them and queues them for the parser.
module xmt_front
    import xmt_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_ready,
    input  logic [7:0] i_data_byte,
    output logic       o_q_valid,
    output t_cls       o_q_cls,
    input  logic       i_q_pop
);

    t_cls       w_cls;
    t_cls       r_ent [2];
    logic       r_wp, r_rp;
    logic [1:0] r_cnt;
    logic       w_push;

    always_comb begin
        w_cls.data  = i_data_byte;
        w_cls.lt    = (i_data_byte == CH_LT);
        w_cls.gt    = (i_data_byte == CH_GT);
        w_cls.slash = (i_data_byte == CH_SLASH);
        w_cls.eq    = (i_data_byte == CH_EQ);
        w_cls.qmark = (i_data_byte == CH_QMARK);
        w_cls.bang  = (i_data_byte == CH_BANG);
        w_cls.dash  = (i_data_byte == CH_DASH);
        w_cls.lbr   = (i_data_byte == CH_LBR);
        w_cls.rbr   = (i_data_byte == CH_RBR);
        w_cls.quote = (i_data_byte == CH_QUOTE);
        w_cls.lf    = (i_data_byte == CH_LF);
        w_cls.blank = (i_data_byte <= CH_SPACE);
    end

    assign o_ready   = (r_cnt != 2'd2);
    assign w_push    = i_valid && o_ready;
    assign o_q_valid = (r_cnt != 2'd0);
    assign o_q_cls   = r_ent[r_rp];

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_ent[r_wp] <= w_cls;
        end
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (w_push) begin
                r_wp <= ~r_wp;
            end
            if (i_q_pop) begin
                r_rp <= ~r_rp;
            end
            r_cnt <= r_cnt + 2'(w_push) - 2'(i_q_pop);
        end
    end

endmodule

// ===== rtl/xmt_back.sv =====
// Back end: markup state machine, name stack, counters and result register.
module xmt_back
    import xmt_pkg::*;
#(
    parameter int STACK_DEPTH = STACK_DEPTH_DEF,
    parameter int NAME_BYTES  = NAME_BYTES_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_q_valid,
    input  t_cls                               i_q_cls,
    output logic                               o_q_pop,
    output logic                               o_valid,
    input  logic                               i_ready,
    output logic [3:0]                         o_event_res,
    output logic [2:0]                         o_byte_role,
    output logic [$clog2(STACK_DEPTH+1)-1:0]   o_depth,
    output logic [31:0]                        o_line_number,
    output logic [31:0]                        o_char_position,
    output logic [31:0]                        o_tag_open_position
);

    localparam int SPW = $clog2(STACK_DEPTH + 1);
    localparam int IW  = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
    localparam int NXW = $clog2(NAME_BYTES + 1);
    localparam int AW  = $clog2(STACK_DEPTH * NAME_BYTES);

    t_state           r_state, n_state, w_st;
    logic             r_pop, n_pop;
    logic [SPW-1:0]   r_sp, n_sp, w_sp;
    logic [NXW-1:0]   r_idx, n_idx;
    logic             r_mm, n_mm;
    logic [31:0]      r_lc, n_lc, r_bc, n_bc, r_lo, n_lo;
    logic [NXW-1:0]   r_len [STACK_DEPTH];

    logic [3:0]       w_ev;
    logic [2:0]       w_role;
    logic             w_we, w_len_we;
    logic [AW-1:0]    w_waddr, w_raddr;
    logic [7:0]       w_rdata;
    logic [IW-1:0]    w_top;
    logic [NXW-1:0]   w_len_top;
    logic             w_full, w_adv;
    logic [SPW-1:0]   w_p_sp, w_p_spe;
    logic [NXW-1:0]   w_p_idx;
    logic [IW-1:0]    w_p_top;

    logic             r_ov;
    logic [3:0]       r_o_ev;
    logic [2:0]       r_o_role;
    logic [SPW-1:0]   r_o_depth;

    assign w_adv   = i_q_valid && (!r_ov || i_ready);
    assign o_q_pop = w_adv;

    assign w_sp      = (r_pop && r_sp != '0) ? r_sp - 1'b1 : r_sp;
    assign w_st      = r_pop ? ST_OUT : r_state;
    assign w_top     = IW'(w_sp - 1'b1);
    assign w_len_top = r_len[w_top];
    assign w_full    = (w_sp >= SPW'(STACK_DEPTH));

    always_comb begin
        n_state  = w_st;
        n_pop    = 1'b0;
        n_sp     = w_sp;
        n_idx    = r_idx;
        n_mm     = r_mm;
        n_bc     = r_bc + 32'd1;
        n_lc     = r_lc + 32'(i_q_cls.lf);
        n_lo     = r_lo;
        w_ev     = EV_NONE;
        w_role   = ROLE_MARKUP;
        w_we     = 1'b0;
        w_len_we = 1'b0;
        w_waddr  = AW'(w_sp) * AW'(NAME_BYTES);
        unique case (w_st)
            ST_OUT, ST_TEXT: begin
                if (i_q_cls.lt) begin
                    n_state = ST_LT;
                    n_lo    = n_bc;
                    n_idx   = '0;
                end else if (w_st == ST_TEXT || w_sp != '0) begin
                    n_state = ST_TEXT;
                    w_role  = ROLE_TEXT;
                end
            end
            ST_LT: begin
                if (i_q_cls.slash) begin
                    n_state = ST_ENAME;
                    n_idx   = '0;
                    n_mm    = 1'b0;
                end else if (i_q_cls.qmark) begin
                    n_state = ST_PI;
                end else if (i_q_cls.bang) begin
                    n_state = ST_BANG;
                end else if (!i_q_cls.blank) begin
                    n_state = ST_NAME;
                    w_role  = ROLE_ELEM;
                    w_we    = !w_full;
                    n_idx   = NXW'(1);
                end
            end
            ST_NAME: begin
                if (i_q_cls.gt || i_q_cls.slash || i_q_cls.blank) begin
                    if (w_full) begin
                        w_ev    = EV_OVERFLOW;
                        n_state = i_q_cls.gt ? ST_OUT : ST_SKIP;
                    end else begin
                        w_len_we = 1'b1;
                        n_sp     = w_sp + 1'b1;
                        if (i_q_cls.gt) begin
                            n_state = ST_OUT;
                            w_ev    = EV_START;
                        end else begin
                            n_state = i_q_cls.slash ? ST_SLASH : ST_ATTRS;
                        end
                    end
                end else if (r_idx >= NXW'(NAME_BYTES)) begin
                    w_ev    = EV_NAME_LONG;
                    n_state = ST_SKIP;
                end else begin
                    w_role  = ROLE_ELEM;
                    w_we    = !w_full;
                    w_waddr = AW'(w_sp) * AW'(NAME_BYTES) + AW'(r_idx);
                    n_idx   = r_idx + 1'b1;
                end
            end
            ST_ATTRS: begin
                if (i_q_cls.gt) begin
                    n_state = ST_OUT;
                    w_ev    = EV_START;
                end else if (i_q_cls.slash) begin
                    n_state = ST_SLASH;
                end else if (!i_q_cls.blank) begin
                    n_state = ST_ANAME;
                    w_role  = ROLE_ANAME;
                end
            end
            ST_ANAME: begin
                if (i_q_cls.eq) begin
                    n_state = ST_EQ;
                end else if (!i_q_cls.blank) begin
                    w_role = ROLE_ANAME;
                end else begin
                    w_ev = EV_ANAME_SP;
                end
            end
            ST_EQ: begin
                if (i_q_cls.quote) begin
                    n_state = ST_VAL;
                end else if (!i_q_cls.blank) begin
                    w_ev = EV_NO_QUOTE;
                end
            end
            ST_VAL: begin
                if (i_q_cls.quote) begin
                    n_state = ST_ATTRS;
                end else begin
                    w_role = ROLE_AVAL;
                end
            end
            ST_SLASH: begin
                if (i_q_cls.gt) begin
                    n_state = ST_OUT;
                    n_pop   = 1'b1;
                    w_ev    = EV_EMPTY;
                end else begin
                    w_ev = EV_NO_GT;
                end
            end
            ST_ENAME, ST_EEND: begin
                if (i_q_cls.gt) begin
                    n_state = ST_OUT;
                    if (w_sp == '0) begin
                        w_ev = EV_UNDERFLOW;
                    end else begin
                        n_pop = 1'b1;
                        w_ev  = (r_mm || r_idx != w_len_top) ? EV_MISMATCH : EV_END;
                    end
                end else if (i_q_cls.blank) begin
                    n_state = ST_EEND;
                end else if (w_st == ST_EEND) begin
                    w_ev = EV_JUNK;
                end else begin
                    w_role = ROLE_ENAME;
                    if (w_sp == '0 || r_idx >= w_len_top || r_idx >= NXW'(NAME_BYTES) ||
                        w_rdata != i_q_cls.data) begin
                        n_mm = 1'b1;
                    end
                    if (r_idx < NXW'(NAME_BYTES)) begin
                        n_idx = r_idx + 1'b1;
                    end
                end
            end
            ST_PI:   n_state = i_q_cls.qmark ? ST_PIQ : ST_PI;
            ST_PIQ:  n_state = i_q_cls.gt ? ST_OUT : ST_PI;
            ST_BANG: begin
                if (i_q_cls.dash) begin
                    n_state = ST_CM0;
                end else if (i_q_cls.lbr) begin
                    n_state = ST_CD0;
                end else begin
                    n_state = ST_SKIP;
                end
            end
            ST_SKIP: n_state = i_q_cls.gt ? ST_OUT : ST_SKIP;
            ST_CM0: begin
                if (i_q_cls.dash) begin
                    n_state = ST_CM1;
                end else begin
                    w_ev = EV_BAD_CMT;
                end
            end
            ST_CM1:  n_state = i_q_cls.dash ? ST_CM2 : ST_CM1;
            ST_CM2:  n_state = i_q_cls.dash ? ST_CM3 : ST_CM1;
            ST_CM3:  n_state = i_q_cls.gt ? ST_OUT : ST_CM1;
            ST_CD0:  n_state = (i_q_cls.data == CH_C) ? ST_CD1 : ST_SKIP;
            ST_CD1:  n_state = (i_q_cls.data == CH_D) ? ST_CD2 : ST_SKIP;
            ST_CD2:  n_state = (i_q_cls.data == CH_A) ? ST_CD3 : ST_SKIP;
            ST_CD3:  n_state = (i_q_cls.data == CH_T) ? ST_CD4 : ST_SKIP;
            ST_CD4:  n_state = (i_q_cls.data == CH_A) ? ST_CD5 : ST_SKIP;
            ST_CD5:  n_state = i_q_cls.lbr ? ST_CDBODY : ST_SKIP;
            ST_CDBODY: n_state = i_q_cls.rbr ? ST_CDB1 : ST_CDBODY;
            ST_CDB1: n_state = i_q_cls.rbr ? ST_CDB2 : ST_CDBODY;
            ST_CDB2: begin
                if (i_q_cls.gt) begin
                    n_state = ST_OUT;
                end else if (!i_q_cls.rbr) begin
                    n_state = ST_CDBODY;
                end
            end
            default: n_state = ST_OUT;
        endcase
    end

    // prefetch the top-name byte that the next transaction may compare against
    always_comb begin
        w_p_sp  = w_adv ? n_sp : r_sp;
        w_p_idx = w_adv ? n_idx : r_idx;
        if ((w_adv ? n_pop : r_pop) && w_p_sp != '0) begin
            w_p_spe = w_p_sp - 1'b1;
        end else begin
            w_p_spe = w_p_sp;
        end
        w_p_top = (w_p_spe != '0) ? IW'(w_p_spe - 1'b1) : '0;
        w_raddr = AW'(w_p_top) * AW'(NAME_BYTES) +
                  ((w_p_idx < NXW'(NAME_BYTES)) ? AW'(w_p_idx) : '0);
    end

    xmt_ram #(
        .WIDTH (8),
        .DEPTH (STACK_DEPTH * NAME_BYTES)
    ) u_names (
        .i_clk   (i_clk),
        .i_we    (w_adv && w_we),
        .i_waddr (w_waddr),
        .i_wdata (i_q_cls.data),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (w_adv && w_len_we) begin
            r_len[IW'(w_sp)] <= r_idx;
        end
        if (w_adv) begin
            r_o_ev    <= w_ev;
            r_o_role  <= w_role;
            r_o_depth <= n_sp;
        end
        if (!i_rst_n) begin
            r_state <= ST_OUT;
            r_pop   <= 1'b0;
            r_sp    <= '0;
            r_idx   <= '0;
            r_mm    <= 1'b0;
            r_lc    <= '0;
            r_bc    <= '0;
            r_lo    <= '0;
            r_ov    <= 1'b0;
        end else begin
            if (w_adv) begin
                r_state <= n_state;
                r_pop   <= n_pop;
                r_sp    <= n_sp;
                r_idx   <= n_idx;
                r_mm    <= n_mm;
                r_lc    <= n_lc;
                r_bc    <= n_bc;
                r_lo    <= n_lo;
                r_ov    <= 1'b1;
            end else if (i_ready) begin
                r_ov <= 1'b0;
            end
        end
    end

    assign o_valid             = r_ov;
    assign o_event_res         = r_o_ev;
    assign o_byte_role         = r_o_role;
    assign o_depth             = r_o_depth;
    assign o_line_number       = r_lc;
    assign o_char_position     = r_bc;
    assign o_tag_open_position = r_lo;

endmodule

// ===== rtl/xml_markup_tokenizer.sv =====
// Top level of the XML markup tokenizer: byte queue front end and parser back end.
// One XML byte in, one result out per transaction, one byte per clock unless stalled.
// Each byte makes one state transition and at most one write to the element-name
// memory; the name byte for an end-tag compare is prefetched by a registered read,
// no reset clearing pass is made, and each byte passes the queue entry and result register.
module xml_markup_tokenizer
    import xmt_pkg::*;
#(
    parameter int STACK_DEPTH = STACK_DEPTH_DEF,
    parameter int NAME_BYTES  = NAME_BYTES_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_valid,
    output logic                             o_ready,
    input  logic [7:0]                       i_data_byte,
    output logic                             o_valid,
    input  logic                             i_ready,
    output logic [3:0]                       o_event_res,
    output logic [2:0]                       o_byte_role,
    output logic [$clog2(STACK_DEPTH+1)-1:0] o_depth,
    output logic [31:0]                      o_line_number,
    output logic [31:0]                      o_char_position,
    output logic [31:0]                      o_tag_open_position
);

    logic w_q_valid, w_q_pop;
    t_cls w_q_cls;

    xmt_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_ready     (o_ready),
        .i_data_byte (i_data_byte),
        .o_q_valid   (w_q_valid),
        .o_q_cls     (w_q_cls),
        .i_q_pop     (w_q_pop)
    );

    xmt_back #(
        .STACK_DEPTH (STACK_DEPTH),
        .NAME_BYTES  (NAME_BYTES)
    ) u_back (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_q_valid           (w_q_valid),
        .i_q_cls             (w_q_cls),
        .o_q_pop             (w_q_pop),
        .o_valid             (o_valid),
        .i_ready             (i_ready),
        .o_event_res         (o_event_res),
        .o_byte_role         (o_byte_role),
        .o_depth             (o_depth),
        .o_line_number       (o_line_number),
        .o_char_position     (o_char_position),
        .o_tag_open_position (o_tag_open_position)
    );

endmodule

// ===== rtl/xmt_checker.sv =====
// Port-level checks for the XML markup tokenizer, bound to the top level.
module xmt_checker
    import xmt_pkg::*;
#(
    parameter int STACK_DEPTH = STACK_DEPTH_DEF
) (
    input logic                             i_clk,
    input logic                             i_rst_n,
    input logic                             i_valid,
    input logic                             o_ready,
    input logic [7:0]                       i_data_byte,
    input logic                             o_valid,
    input logic                             i_ready,
    input logic [3:0]                       o_event_res,
    input logic [2:0]                       o_byte_role,
    input logic [$clog2(STACK_DEPTH+1)-1:0] o_depth,
    input logic [31:0]                      o_char_position
);

    logic        r_seen;
    logic [31:0] r_last_pos;

    always_ff @(posedge i_clk) begin
        if (o_valid && i_ready) begin
            r_last_pos <= o_char_position;
        end
        if (!i_rst_n) begin
            r_seen <= 1'b0;
        end else if (o_valid && i_ready) begin
            r_seen <= 1'b1;
        end
    end

    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !o_ready |=> i_valid && $stable(i_data_byte))
        else $error("input transaction changed while waiting");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_char_position))
        else $error("result dropped while stalled");

    a_pos_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_ready && r_seen |-> o_char_position == r_last_pos + 32'd1)
        else $error("character position skipped or repeated");

    a_depth_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_depth <= ($clog2(STACK_DEPTH+1))'(STACK_DEPTH))
        else $error("depth beyond stack size");

    a_event_role: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_event_res != EV_NONE |-> o_byte_role == ROLE_MARKUP &&
        o_event_res <= EV_NAME_LONG)
        else $error("bad event or role on event byte");

endmodule

bind xml_markup_tokenizer xmt_checker #(.STACK_DEPTH(STACK_DEPTH)) u_xmt_checker (.*);
